>>> rtl/top_k_logit_selector_macros.svh
// Assertion macros for the top-k logit selector.
// Included by the top level; the including scope supplies clk and rst_n.
`ifndef TOP_K_LOGIT_SELECTOR_MACROS_SVH
`define TOP_K_LOGIT_SELECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define TKLS_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define TKLS_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tkls_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the top-k logit selector.
// No dependencies; imported by every module of the block.
package tkls_pkg;

    localparam int K_MAX_DEF   = 64;
    localparam int ID_BITS_DEF = 18;
    localparam int LOGIT_W     = 32;
    localparam int RANK_W      = 6;
    localparam int CFG_W       = 10;
    localparam int QDEPTH      = 4;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] REG_K_REQUESTED    = 2'd0;
    localparam logic [1:0] REG_MIN_KEEP_COUNT = 2'd1;
    localparam logic [1:0] REG_INPUT_PRESORTED = 2'd2;

    localparam logic [CFG_W-1:0] K_REQUESTED_RST    = 10'd40;
    localparam logic [CFG_W-1:0] MIN_KEEP_COUNT_RST = 10'd1;

    typedef struct packed {
        logic last;
        logic presorted;
    } item_ctrl_t;

    typedef struct packed {
        logic [CFG_W-1:0] k_requested;
        logic [CFG_W-1:0] min_keep_count;
    } sel_cfg_t;

endpackage

>>> rtl/tkls_front.sv
`timescale 1ns / 1ps
// Front end: accepts candidate beats, tags them with the ordering mode and queues them.
// Depends on tkls_pkg.
module tkls_front
    import tkls_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [ID_BITS-1:0]        token_id,
    input  logic signed [LOGIT_W-1:0] logit_value,
    input  logic                      last_item,
    input  logic                      presorted,
    output logic                      q_valid,
    input  logic                      q_pop,
    output logic [ID_BITS-1:0]        q_id,
    output logic signed [LOGIT_W-1:0] q_logit,
    output item_ctrl_t                q_ctrl
);

    localparam int PTR_W = $clog2(QDEPTH);

    logic [ID_BITS-1:0]        id_mem_reg    [QDEPTH];
    logic signed [LOGIT_W-1:0] logit_mem_reg [QDEPTH];
    item_ctrl_t                ctrl_mem_reg  [QDEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign full    = (count_reg == (PTR_W+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign wr_en   = push && !full;
    assign rd_en   = q_pop && q_valid;

    assign q_id    = id_mem_reg[rd_ptr_reg];
    assign q_logit = logit_mem_reg[rd_ptr_reg];
    assign q_ctrl  = ctrl_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem_reg[wr_ptr_reg]    <= token_id;
            logit_mem_reg[wr_ptr_reg] <= logit_value;
            ctrl_mem_reg[wr_ptr_reg]  <= '{last: last_item, presorted: presorted};
        end
    end

endmodule

>>> rtl/tkls_back.sv
`timescale 1ns / 1ps
// Back end: compare-and-shift cell chain holding the kept candidates, and the
// sequencer that drains them in rank order into the result register. Depends on tkls_pkg.
module tkls_back
    import tkls_pkg::*;
#(
    parameter int K_MAX   = K_MAX_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sel_cfg_t                  cfg,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  logic [ID_BITS-1:0]        q_id,
    input  logic signed [LOGIT_W-1:0] q_logit,
    input  item_ctrl_t                q_ctrl,
    output logic                      draining,
    output logic                      empty,
    input  logic                      pop,
    output logic [ID_BITS-1:0]        kept_id,
    output logic signed [LOGIT_W-1:0] kept_logit,
    output logic [RANK_W-1:0]         rank,
    output logic                      last_result
);

    localparam int HELD_W = $clog2(K_MAX + 1);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_DRAIN = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [ID_BITS-1:0]        cell_id_reg    [K_MAX];
    logic signed [LOGIT_W-1:0] cell_logit_reg [K_MAX];

    logic [HELD_W-1:0] held_reg, held_next;
    logic [HELD_W-1:0] eff_reg, eff_next;
    logic [HELD_W-1:0] rank_cnt_reg, rank_cnt_next;

    logic                      out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]        out_id_reg;
    logic signed [LOGIT_W-1:0] out_logit_reg;
    logic [RANK_W-1:0]         out_rank_reg;
    logic                      out_last_reg;

    logic             take;
    logic             emit;
    logic             drain_done;
    logic [K_MAX-1:0] gt;
    logic [K_MAX-1:0] lead_hit;
    logic [CFG_W-1:0] k_floor;
    logic             held_full;

    assign take       = (state_reg == ST_RUN) && q_valid;
    assign q_pop      = take;
    assign draining   = (state_reg == ST_DRAIN);
    assign held_full  = (held_reg == HELD_W'(K_MAX));
    assign drain_done = draining && (rank_cnt_reg == eff_reg);
    assign emit       = draining && !drain_done && (!out_valid_reg || pop);

    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            gt[i] = (HELD_W'(i) >= held_reg) ||
                    (!q_ctrl.presorted && (q_logit > cell_logit_reg[i]));
        end
        for (int i = 0; i < K_MAX; i++)
        begin
            lead_hit[i] = |(gt & ~({K_MAX{1'b1}} << i));
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (take && !held_full)
        begin
            held_next = held_reg + HELD_W'(1);
        end
        else if (drain_done)
        begin
            held_next = '0;
        end

        k_floor  = (cfg.k_requested > cfg.min_keep_count) ? cfg.k_requested
                                                           : cfg.min_keep_count;
        eff_next = eff_reg;
        if (take && q_ctrl.last)
        begin
            eff_next = (k_floor < CFG_W'(held_next)) ? HELD_W'(k_floor) : held_next;
        end

        state_next    = state_reg;
        rank_cnt_next = rank_cnt_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (take && q_ctrl.last)
                begin
                    state_next    = ST_DRAIN;
                    rank_cnt_next = '0;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_RUN;
                end
                else if (emit)
                begin
                    rank_cnt_next = rank_cnt_reg + HELD_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            held_reg      <= '0;
            eff_reg       <= '0;
            rank_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            eff_reg       <= eff_next;
            rank_cnt_reg  <= rank_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg    <= cell_id_reg[0];
            out_logit_reg <= cell_logit_reg[0];
            out_rank_reg  <= RANK_W'(rank_cnt_reg);
            out_last_reg  <= ((rank_cnt_reg + HELD_W'(1)) == eff_reg);
        end
    end

    for (genvar g = 0; g < K_MAX; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (take)
            begin
                if (lead_hit[g])
                begin
                    if (g > 0)
                    begin
                        cell_id_reg[g]    <= cell_id_reg[(g > 0) ? g - 1 : 0];
                        cell_logit_reg[g] <= cell_logit_reg[(g > 0) ? g - 1 : 0];
                    end
                end
                else if (gt[g])
                begin
                    cell_id_reg[g]    <= q_id;
                    cell_logit_reg[g] <= q_logit;
                end
            end
            else if (emit)
            begin
                if (g < K_MAX - 1)
                begin
                    cell_id_reg[g]    <= cell_id_reg[(g < K_MAX - 1) ? g + 1 : g];
                    cell_logit_reg[g] <= cell_logit_reg[(g < K_MAX - 1) ? g + 1 : g];
                end
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign kept_id     = out_id_reg;
    assign kept_logit  = out_logit_reg;
    assign rank        = out_rank_reg;
    assign last_result = out_last_reg;

endmodule

>>> rtl/top_k_logit_selector.sv
// A pushed candidate is written into the front queue, then taken into the cell chain while
// the back end runs; after the last candidate the back end drains the cell chain head into
// the result register. Throughput: one candidate per cycle through the cell chain outside a
// drain; during a drain the queue fills but no candidate is inserted.
// Reset (rst_n, asynchronous, active low) empties the queue, the cell chain count and
// the result register, and restores the register defaults.
`timescale 1ns / 1ps
// Top level: configuration registers on the APB port, front queue and back cell chain.
// Depends on tkls_pkg, tkls_front, tkls_back and top_k_logit_selector_macros.svh.
`include "top_k_logit_selector_macros.svh"
module top_k_logit_selector
    import tkls_pkg::*;
#(
    parameter int K_MAX   = K_MAX_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      push,
    output logic                      full,
    input  logic [ID_BITS-1:0]        token_id,
    input  logic signed [LOGIT_W-1:0] logit_value,
    input  logic                      last_item,
    output logic                      empty,
    input  logic                      pop,
    output logic [ID_BITS-1:0]        kept_id,
    output logic signed [LOGIT_W-1:0] kept_logit,
    output logic [RANK_W-1:0]         rank,
    output logic                      last_result
);

    logic [CFG_W-1:0] k_requested_reg;
    logic [CFG_W-1:0] min_keep_count_reg;
    logic             input_presorted_reg;
    logic             cfg_wr;
    logic [1:0]       reg_idx;
    sel_cfg_t         cfg;

    logic                      q_valid;
    logic                      q_pop;
    logic [ID_BITS-1:0]        q_id;
    logic signed [LOGIT_W-1:0] q_logit;
    item_ctrl_t                q_ctrl;
    logic                      draining;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_requested_reg     <= K_REQUESTED_RST;
            min_keep_count_reg  <= MIN_KEEP_COUNT_RST;
            input_presorted_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_K_REQUESTED:     k_requested_reg     <= pwdata[CFG_W-1:0];
                REG_MIN_KEEP_COUNT:  min_keep_count_reg  <= pwdata[CFG_W-1:0];
                REG_INPUT_PRESORTED: input_presorted_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_K_REQUESTED:     prdata = PDATA_W'(k_requested_reg);
            REG_MIN_KEEP_COUNT:  prdata = PDATA_W'(min_keep_count_reg);
            REG_INPUT_PRESORTED: prdata = PDATA_W'(input_presorted_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg = '{k_requested: k_requested_reg, min_keep_count: min_keep_count_reg};

    tkls_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .token_id    (token_id),
        .logit_value (logit_value),
        .last_item   (last_item),
        .presorted   (input_presorted_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_id        (q_id),
        .q_logit     (q_logit),
        .q_ctrl      (q_ctrl)
    );

    tkls_back #(
        .K_MAX   (K_MAX),
        .ID_BITS (ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_id        (q_id),
        .q_logit     (q_logit),
        .q_ctrl      (q_ctrl),
        .draining    (draining),
        .empty       (empty),
        .pop         (pop),
        .kept_id     (kept_id),
        .kept_logit  (kept_logit),
        .rank        (rank),
        .last_result (last_result)
    );

    `TKLS_ASSERT_NEXT(a_push_reaches_queue, push && !full, q_valid, "Accepted beat missing from queue")
    `TKLS_ASSERT_SAME(a_no_insert_in_drain, draining, !q_pop, "Candidate taken during drain")
    `TKLS_ASSERT_NEXT(a_last_starts_drain, q_pop && q_ctrl.last, draining, "Last candidate did not start drain")

endmodule
